### design/lhq_pkg.sv
// ----------------------------------------------------------------------------
// Lane hysteresis quantizer package
// Shared types, codes and constants of the quantizer block.
// ----------------------------------------------------------------------------
package lhq_pkg;

  localparam int SEL_W   = 7;
  localparam int VOLT_W  = 16;
  localparam int STEP_W  = 22;
  localparam int V2_W    = 23;
  localparam int ACC_W   = 26;
  localparam int PROD_W  = 30;
  localparam int CNT_W   = 5;

  localparam logic [STEP_W-1:0] FULL_SCALE_Q9 = 22'd2560000;
  localparam logic [CNT_W-1:0]  DIV_LAST      = 5'd21;
  localparam logic [7:0]        N_MAX         = 8'd128;
  localparam logic [13:0]       V_MAX_MV      = 14'd10000;
  localparam logic [SEL_W-1:0]  PRESET_MAX    = 7'd127;

  localparam logic [7:0] REG_SWITCH_COUNT = 8'd0;
  localparam logic [7:0] REG_HYST_FRAC    = 8'd1;

  localparam logic OP_QUANTIZE = 1'b0;
  localparam logic OP_PRESET   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULH,
    ST_MULO,
    ST_UP,
    ST_DOWN,
    ST_DONE
  } lhq_state_e;

endpackage

### design/lhq_ifs.sv
// ----------------------------------------------------------------------------
// Lane hysteresis quantizer channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface lhq_in_if import lhq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        lane;
  logic [VOLT_W-1:0] voltage_mv;
  logic              voltage_finite;
  logic [VOLT_W-1:0] preset_value;

  modport source (output valid, operation, lane, voltage_mv, voltage_finite, preset_value,
                  input ready);
  modport sink   (input valid, operation, lane, voltage_mv, voltage_finite, preset_value,
                  output ready);
endinterface

interface lhq_out_if import lhq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] selection;

  modport source (output valid, selection, input ready);
  modport sink   (input valid, selection, output ready);
endinterface

interface lhq_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/lhq_ram.sv
// ----------------------------------------------------------------------------
// Lane hysteresis quantizer RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lhq_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/lane_hysteresis_quantizer.sv
// ----------------------------------------------------------------------------
// Lane hysteresis quantizer
// Maps a lane's control voltage to a switch position with hysteresis,
// keeping the last position of every lane.
// ----------------------------------------------------------------------------
// A quantize item runs from the accept state through the bit-serial step
// divider, the shared multiplier (hysteresis, then odd threshold), an upward
// and a downward walk over the positions, and the hand-off state.
// Presets, out-of-range lanes and switch counts of one or less go straight to hand-off.
// One item is in flight at a time; the result register frees the input side.
// Reset sets switch_count to 2, hysteresis_fraction to 64 and all lanes to 0.
module lane_hysteresis_quantizer import lhq_pkg::*; #(
  parameter int LANES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lhq_in_if.sink     in_i,
  lhq_out_if.source  out_o,
  lhq_cfg_if.sink    cfg_i
);
  localparam int LaneAw = (LANES > 1) ? $clog2(LANES) : 1;

  lhq_state_e state_q, state_d;

  logic [7:0]        sc_q, hf_q;
  logic [LANES-1:0]  valid_q, valid_d;
  logic [SEL_W-1:0]  default_q, default_d;
  logic              out_valid_q, out_valid_d;
  logic [SEL_W-1:0]  out_sel_q, out_sel_d;
  logic              wr_q, wr_d;

  logic [7:0]        lane_q, lane_d;
  logic [V2_W-1:0]   v2_q, v2_d;
  logic [STEP_W-1:0] quo_q, quo_d;
  logic [SEL_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [V2_W-1:0]   hyst2_q, hyst2_d;
  logic signed [ACC_W-1:0] odd_q, odd_d;
  logic [SEL_W-1:0]  pos_q, pos_d;
  logic [SEL_W-1:0]  result_q, result_d;

  logic [7:0]        n;
  logic [SEL_W-1:0]  nm1;
  logic              in_acc, out_free;
  logic [7:0]        rem_sh;
  logic              ge;
  logic [7:0]        mul_b;
  logic [PROD_W-1:0] prod;
  logic [SEL_W-1:0]  rdata, stored, pos_start;
  logic signed [ACC_W-1:0] v2s, hyst2s, step2s, up_thr, dn_thr;
  logic signed [VOLT_W-1:0] mv, pv;
  logic [13:0]       v_clamp;
  logic [SEL_W-1:0]  p_clamp;
  logic              ram_we;

  lhq_ram #(
    .WIDTH (SEL_W),
    .DEPTH (LANES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lane_q[LaneAw-1:0]),
    .wdata_i (result_q),
    .raddr_i (lane_q[LaneAw-1:0]),
    .rdata_o (rdata)
  );

  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.selection = out_sel_q;

  assign n        = (sc_q > N_MAX) ? N_MAX : sc_q;
  assign nm1      = 7'(n - 8'd1);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign mv = $signed(in_i.voltage_mv);
  assign pv = $signed(in_i.preset_value);
  assign v_clamp = (!in_i.voltage_finite || mv < 0) ? 14'd0 :
                   (mv > $signed({2'b00, V_MAX_MV})) ? V_MAX_MV : in_i.voltage_mv[13:0];
  assign p_clamp = (pv < 0) ? 7'd0 :
                   (pv > $signed({9'd0, PRESET_MAX})) ? PRESET_MAX : in_i.preset_value[6:0];

  assign rem_sh = {rem_q, quo_q[STEP_W-1]};
  assign ge     = rem_sh >= {1'b0, nm1};

  assign stored    = valid_q[lane_q[LaneAw-1:0]] ? rdata : default_q;
  assign pos_start = (stored > nm1) ? nm1 : stored;
  assign mul_b     = (state_q == ST_MULH) ? hf_q : {pos_start, 1'b1};
  assign prod      = PROD_W'(quo_q) * PROD_W'(mul_b);

  assign v2s    = $signed({3'b000, v2_q});
  assign hyst2s = $signed({3'b000, hyst2_q});
  assign step2s = $signed({3'b000, quo_q, 1'b0});
  assign up_thr = odd_q + hyst2s;
  assign dn_thr = odd_q - step2s - hyst2s;

  assign ram_we = (state_q == ST_DONE) && out_free && wr_q;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    default_d   = default_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_sel_d   = out_sel_q;
    wr_d        = wr_q;
    lane_d      = lane_q;
    v2_d        = v2_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    hyst2_d     = hyst2_q;
    odd_d       = odd_q;
    pos_d       = pos_q;
    result_d    = result_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lane_d = in_i.lane;
          v2_d   = {v_clamp, 9'd0};
          quo_d  = FULL_SCALE_Q9;
          rem_d  = '0;
          cnt_d  = '0;
          wr_d   = 1'b0;
          result_d = '0;
          if (in_i.operation == OP_PRESET) begin
            valid_d   = '0;
            default_d = p_clamp;
            result_d  = p_clamp;
            state_d   = ST_DONE;
          end else if (in_i.lane >= 8'(LANES)) begin
            state_d = ST_DONE;
          end else if (n <= 8'd1) begin
            wr_d    = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = ge ? 7'(rem_sh - {1'b0, nm1}) : rem_sh[SEL_W-1:0];
        quo_d = {quo_q[STEP_W-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_MULH;
        end
      end
      ST_MULH: begin
        hyst2_d = {prod[PROD_W-1:8], 1'b0};
        state_d = ST_MULO;
      end
      ST_MULO: begin
        odd_d   = $signed({1'b0, prod[ACC_W-2:0]});
        pos_d   = pos_start;
        state_d = ST_UP;
      end
      ST_UP: begin
        if ((({1'b0, pos_q} + 8'd1) < n) && (v2s > up_thr)) begin
          pos_d = pos_q + 7'd1;
          odd_d = odd_q + step2s;
        end else begin
          state_d = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if ((pos_q != '0) && (v2s < dn_thr)) begin
          pos_d = pos_q - 7'd1;
          odd_d = odd_q - step2s;
        end else begin
          result_d = pos_q;
          wr_d     = 1'b1;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sel_d   = result_q;
          if (wr_q) begin
            valid_d[lane_q[LaneAw-1:0]] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sc_q        <= 8'd2;
      hf_q        <= 8'd64;
      valid_q     <= '0;
      default_q   <= '0;
      out_valid_q <= 1'b0;
      wr_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      default_q   <= default_d;
      out_valid_q <= out_valid_d;
      wr_q        <= wr_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SWITCH_COUNT: sc_q <= cfg_i.data;
          REG_HYST_FRAC:    hf_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_sel_q <= out_sel_d;
    lane_q    <= lane_d;
    v2_q      <= v2_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    hyst2_q   <= hyst2_d;
    odd_q     <= odd_d;
    pos_q     <= pos_d;
    result_q  <= result_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < nm1))
    else $error("Divider remainder is not below the divisor.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UP || state_q == ST_DOWN) |-> ({1'b0, pos_q} < n))
    else $error("Walked position left the valid range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == OP_PRESET) |=> (valid_q == '0))
    else $error("Preset item left a lane marked as written.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("Result item appeared outside the hand-off state.");
endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Lane hysteresis quantizer testbench
// Drives quantize and preset items through the valid/ready channels, writes
// the two registers between phases, and checks every returned selection
// against a local model that keeps its own copy of the lane positions.
// ----------------------------------------------------------------------------
module testbench import lhq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LANES = 16;
  localparam int LANE_AW   = $clog2(NUM_LANES);
  localparam logic [7:0] REG_BEYOND_LIST = 8'd2;
  localparam logic [7:0] REG_LAST_INDEX  = 8'hFF;

  typedef struct {
    logic              op;
    logic [7:0]        lane;
    logic [VOLT_W-1:0] voltage;
    logic              finite;
    logic [VOLT_W-1:0] preset;
    bit                drain_first;
  } lhq_item_t;

  logic clk_i;
  logic rst_ni;

  lhq_in_if  in_if ();
  lhq_out_if out_if ();
  lhq_cfg_if cfg_if ();

  lane_hysteresis_quantizer #(.LANES(NUM_LANES)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [7:0]       sel_count_reg = 8'd2;
  logic [7:0]       hyst_frac_reg = 8'd64;
  logic [SEL_W-1:0] lane_pos [NUM_LANES] = '{default: '0};

  lhq_item_t        pending_items [$];
  logic [SEL_W-1:0] expected_selections [$];
  lhq_item_t        next_item;
  lhq_item_t        seen_item;
  logic [SEL_W-1:0] wanted;

  bit in_fire  = 1'b0;
  bit cfg_fire = 1'b0;
  bit idle_on  = 1'b1;
  bit hold_done = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int quantizes_seen = 0;
  int off_lane_seen = 0;
  int presets_seen = 0;
  int register_writes = 0;
  int mismatches = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned active_positions();
    return (sel_count_reg > N_MAX) ? int'(N_MAX) : int'(sel_count_reg);
  endfunction

  function automatic longint step_q9(int unsigned n);
    return longint'(FULL_SCALE_Q9) / longint'(n - 1);
  endfunction

  function automatic longint hyst_doubled(longint step);
    return 2 * ((step * longint'(hyst_frac_reg)) >>> 8);
  endfunction

  function automatic logic [SEL_W-1:0] predict_selection(lhq_item_t it);
    int unsigned n;
    int          mv;
    int          level;
    int unsigned pos;
    longint      step;
    longint      hyst2;
    longint      v2;
    n = active_positions();
    if (it.op == OP_PRESET) begin
      level = int'($signed(it.preset));
      if (level < 0) level = 0;
      if (level > int'(PRESET_MAX)) level = int'(PRESET_MAX);
      foreach (lane_pos[i]) lane_pos[i] = level[SEL_W-1:0];
      return level[SEL_W-1:0];
    end
    if (it.lane >= NUM_LANES || n <= 1) begin
      if (it.lane < NUM_LANES) lane_pos[it.lane[LANE_AW-1:0]] = '0;
      return '0;
    end
    mv = int'($signed(it.voltage));
    if (!it.finite || mv < 0) mv = 0;
    if (mv > int'(V_MAX_MV)) mv = int'(V_MAX_MV);
    step = step_q9(n);
    hyst2 = hyst_doubled(step);
    v2 = longint'(mv) * 512;
    pos = 32'(lane_pos[it.lane[LANE_AW-1:0]]);
    if (pos > n - 1) pos = n - 1;
    while (pos + 1 < n && v2 > longint'(2 * pos + 1) * step + hyst2) pos++;
    while (pos > 0 && v2 < longint'(2 * pos - 1) * step - hyst2) pos--;
    lane_pos[it.lane[LANE_AW-1:0]] = pos[SEL_W-1:0];
    return pos[SEL_W-1:0];
  endfunction

  function automatic lhq_item_t make_quantize(logic [7:0] lane, int mv, logic finite);
    lhq_item_t it;
    it.op = OP_QUANTIZE;
    it.lane = lane;
    it.voltage = mv[VOLT_W-1:0];
    it.finite = finite;
    it.preset = VOLT_W'($urandom());
    it.drain_first = 1'b0;
    return it;
  endfunction

  function automatic lhq_item_t make_preset(int value);
    lhq_item_t it;
    it = make_quantize(8'($urandom()), int'($urandom()), 1'($urandom()));
    it.op = OP_PRESET;
    it.preset = value[VOLT_W-1:0];
    return it;
  endfunction

  // Voltage just below, at or above one of the switching thresholds.
  function automatic int boundary_mv();
    int unsigned n;
    int unsigned p;
    int          d;
    longint      step;
    longint      hyst2;
    longint      b;
    n = active_positions();
    if (n < 2) return $urandom_range(0, 10000);
    step = step_q9(n);
    hyst2 = hyst_doubled(step);
    p = $urandom_range(0, n - 1);
    if ($urandom_range(0, 1) != 0) b = longint'(2 * p + 1) * step + hyst2;
    else b = (longint'(2 * p) - 1) * step - hyst2;
    d = $urandom_range(0, 2);
    b = b / 512 + d - 1;
    if (b > 32767) b = 32767;
    if (b < -32768) b = -32768;
    return int'(b);
  endfunction

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_selections.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_register(logic [7:0] index, logic [7:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_if.valid <= 1'b0;
    register_writes++;
  endtask

  task automatic run_phase(logic [7:0] switches, logic [7:0] hyst, int count, bit idle);
    lhq_item_t   it;
    int          i;
    int          sweep_left;
    int          v;
    int          stride;
    int          pick;
    int          extreme_mv [6];
    logic [7:0]  sweep_lane;
    extreme_mv = '{-32768, -1, 0, 10000, 10001, 32767};
    wait_idle();
    write_register(REG_SWITCH_COUNT, switches);
    write_register(REG_HYST_FRAC, hyst);
    idle_on = idle;
    sweep_left = 0;
    v = 0;
    stride = 0;
    sweep_lane = '0;
    for (i = 0; i < count; i++) begin
      if (sweep_left == 0 && $urandom_range(0, 9) < 4) begin
        sweep_lane = 8'($urandom_range(0, NUM_LANES - 1));
        sweep_left = $urandom_range(6, 14);
        v = ($urandom_range(0, 1) != 0) ? 10000 : 0;
        stride = $urandom_range(50, 1200);
        if (v != 0) stride = -stride;
      end
      if (sweep_left > 0) begin
        it = make_quantize(sweep_lane, v, ($urandom_range(0, 15) != 0));
        v += stride;
        if (v > 10600 || v < -600) stride = -stride;
        sweep_left--;
      end else if ($urandom_range(0, 24) == 0) begin
        it = make_preset(($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 130))
                                                    : int'($urandom()));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 16) it.lane = 8'($urandom_range(0, NUM_LANES - 1));
        else if (pick < 18) it.lane = 8'($urandom_range(NUM_LANES, 255));
        else it.lane = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          5:       v = $urandom();
          6, 9:    v = boundary_mv();
          7:       v = extreme_mv[$urandom_range(0, 5)];
          8:       v = ($urandom_range(0, 1) != 0) ? int'($urandom_range(9900, 10100))
                                                   : int'($urandom_range(0, 100)) - 50;
          default: v = $urandom_range(0, 10000);
        endcase
        it = make_quantize(it.lane, v, ($urandom_range(0, 9) != 0));
      end
      it.drain_first = (i == count / 2);
      pending_items.push_back(it);
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid          <= 1'b0;
      in_if.operation      <= OP_QUANTIZE;
      in_if.lane           <= '0;
      in_if.voltage_mv     <= '0;
      in_if.voltage_finite <= 1'b0;
      in_if.preset_value   <= '0;
    end else if (!in_if.valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain_first && expected_selections.size() != 0)) begin
        in_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        tx_gap <= $urandom_range(0, 5);
        in_if.valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        in_if.valid          <= 1'b1;
        in_if.operation      <= next_item.op;
        in_if.lane           <= next_item.lane;
        in_if.voltage_mv     <= next_item.voltage;
        in_if.voltage_finite <= next_item.finite;
        in_if.preset_value   <= next_item.preset;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_accepted >= 200) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 5);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    in_fire  <= in_if.valid && in_if.ready;
    cfg_fire <= cfg_if.valid && cfg_if.ready;
    if (in_if.valid && in_if.ready) begin
      seen_item.op          = in_if.operation;
      seen_item.lane        = in_if.lane;
      seen_item.voltage     = in_if.voltage_mv;
      seen_item.finite      = in_if.voltage_finite;
      seen_item.preset      = in_if.preset_value;
      seen_item.drain_first = 1'b0;
      if (seen_item.op == OP_PRESET) presets_seen++;
      else if (seen_item.lane >= NUM_LANES) off_lane_seen++;
      else quantizes_seen++;
      expected_selections.push_back(predict_selection(seen_item));
      items_accepted++;
    end
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.index == REG_SWITCH_COUNT) sel_count_reg = cfg_if.data;
      else if (cfg_if.index == REG_HYST_FRAC) hyst_frac_reg = cfg_if.data;
    end
    if (out_if.valid && out_if.ready) begin
      results_checked++;
      if (expected_selections.size() == 0) begin
        if (mismatches < 10)
          $display("Selection %0d arrived with no item outstanding", out_if.selection);
        mismatches++;
      end else begin
        wanted = expected_selections.pop_front();
        if (out_if.selection !== wanted) begin
          if (mismatches < 10)
            $display("Selection mismatch: expected %0d, got %0d", wanted, out_if.selection);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: two positions, thresholds at 2500 mV and 7500 mV.
    pending_items.push_back(make_quantize(8'd0, 7500, 1'b1));
    pending_items.push_back(make_quantize(8'd0, 7501, 1'b1));
    pending_items.push_back(make_quantize(8'd0, 2500, 1'b1));
    pending_items.push_back(make_quantize(8'd0, 2499, 1'b1));
    pending_items.push_back(make_quantize(8'd0, 32767, 1'b1));
    pending_items.push_back(make_quantize(8'd0, -32768, 1'b1));
    pending_items.push_back(make_quantize(8'd0, 10000, 1'b1));
    pending_items.push_back(make_quantize(8'd0, 10000, 1'b0));
    pending_items.push_back(make_quantize(8'd15, -1, 1'b1));
    pending_items.push_back(make_quantize(8'd15, 10001, 1'b1));
    pending_items.push_back(make_quantize(8'd16, 9000, 1'b1));
    pending_items.push_back(make_quantize(8'd255, 32767, 1'b0));
    pending_items.push_back(make_preset(32767));
    pending_items.push_back(make_quantize(8'd3, 5000, 1'b1));
    pending_items.push_back(make_preset(-32768));
    pending_items.push_back(make_preset(128));
    pending_items.push_back(make_preset(127));
    pending_items.push_back(make_preset(0));
    pending_items.push_back(make_preset(63));
    pending_items.push_back(make_quantize(8'd7, 0, 1'b1));
    pending_items.push_back(make_quantize(8'd8, 8000, 1'b1));

    run_phase(8'd8, 8'd64, 150, 1'b1);
    run_phase(8'd128, 8'd0, 150, 1'b1);
    run_phase(8'd255, 8'd255, 120, 1'b1);
    run_phase(8'd0, 8'd17, 40, 1'b1);
    run_phase(8'd1, 8'd200, 40, 1'b1);
    wait_idle();
    write_register(REG_BEYOND_LIST, 8'($urandom()));
    write_register(REG_LAST_INDEX, 8'($urandom()));
    run_phase(8'd16, 8'd128, 150, 1'b1);
    run_phase(8'd129, 8'd32, 120, 1'b0);
    run_phase(8'd3, 8'd255, 120, 1'b1);
    run_phase(8'd64, 8'd1, 150, 1'b1);
    run_phase(8'd2, 8'd0, 100, 1'b1);
    run_phase(8'd100, 8'($urandom_range(0, 255)), 150, 1'b0);

    wait_idle();
    repeat (300) @(posedge clk_i);
    $display("Checked %0d selections: %0d quantize items, %0d on lanes past the end, %0d presets.",
             results_checked, quantizes_seen, off_lane_seen, presets_seen);
    $display("Made %0d register writes, switch counts and hysteresis fractions 0 to 255.",
             register_writes);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d selections still outstanding", expected_selections.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
